// File: rtl/core/button_autorepeat_stick_threshold_macros.svh
// Assertion macros for the button autorepeat block.
// Expect signals clk and rst_n in the scope of each use.
`ifndef BUTTON_AUTOREPEAT_STICK_THRESHOLD_MACROS_SVH
`define BUTTON_AUTOREPEAT_STICK_THRESHOLD_MACROS_SVH
`ifndef SYNTHESIS
`define BAR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define BAR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BAR_ASSERT_IMP(label, ante, cons)
`define BAR_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/core/bar_pkg.sv
// Shared types and constants for the button autorepeat block.
// No dependencies; used by bar_button_lane and the top level.
`default_nettype none
package bar_pkg;

    localparam int BTN_W       = 12;
    localparam int STICK_W     = 8;
    localparam int NOW_W       = 32;
    localparam int DELAY_W     = 12;
    localparam int DIRS_W      = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;

    localparam int NUM_BUTTONS_DEF = 12;
    localparam int TIME_WIDTH_DEF  = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_AUTOREPEAT_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DELAY       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STICK_LOW         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STICK_HIGH        = 3'd4;

    // Reset values
    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST     = 12'd400;
    localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = 12'd50;
    localparam logic [STICK_W-1:0] STICK_LOW_RST       = 8'd32;
    localparam logic [STICK_W-1:0] STICK_HIGH_RST      = 8'd224;

    // Direction bit positions
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    typedef struct packed {
        logic               advance;
        logic               autorepeat;
        logic [DELAY_W-1:0] first_delay;
        logic [DELAY_W-1:0] repeat_interval;
    } bar_lane_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/bar_button_lane.sv
// One button's autorepeat state: armed flag and deadline.
// Depends on bar_pkg for the lane control struct.
`default_nettype none
module bar_button_lane
    import bar_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bar_lane_ctl_t         ctl,
    input  wire logic                  held,
    input  wire logic [TIME_WIDTH-1:0] now,
    output logic                       report
);

    logic                  armed_reg;
    logic                  armed_next;
    logic [TIME_WIDTH-1:0] deadline_reg;
    logic [TIME_WIDTH-1:0] deadline_next;
    logic [DELAY_W-1:0]    gap;
    logic                  due;

    assign due = !armed_reg || (now >= deadline_reg);

    always_comb
    begin
        report        = 1'b0;
        armed_next    = armed_reg;
        deadline_next = deadline_reg;
        gap           = ctl.first_delay;
        if (!held)
        begin
            // release: disarm
            armed_next    = 1'b0;
            deadline_next = '0;
        end
        else if (!ctl.autorepeat || due)
        begin
            if (ctl.autorepeat && armed_reg)
                gap = ctl.repeat_interval;
            report        = 1'b1;
            armed_next    = 1'b1;
            deadline_next = now + {{(TIME_WIDTH-DELAY_W){1'b0}}, gap};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= 1'b0;
            deadline_reg <= '0;
        end
        else if (ctl.advance)
        begin
            armed_reg    <= armed_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/button_autorepeat_stick_threshold.sv
// Top level: controller sample conditioner with button autorepeat and stick thresholds.
// Depends on bar_pkg, bar_button_lane and the assertion macro header.
//
//  channel | signals                          | direction | accepted when
//  --------+----------------------------------+-----------+-----------------------
//  in      | in_valid, in_stall, sample flds  | in        | in_valid && !in_stall
//  out     | out_valid, out_stall, result flds| out       | out_valid && !out_stall
//  cfg     | cfg_wr_en, cfg_index, cfg_data   | in        | cfg_wr_en
//
// One transaction per cycle sustained while out_stall is low; each item passes the input
// register, then the result register. The per-button compare and add sit between them.
// Reset clears the valid flags, armed flags and deadlines and loads the config reset
// values; the block takes a transaction right after reset. in_stall rises only when
// the input register is full and the result register is full and stalled.
`default_nettype none
`include "button_autorepeat_stick_threshold_macros.svh"
module button_autorepeat_stick_threshold
    import bar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [BTN_W-1:0]       buttons_held,
    input  wire logic [STICK_W-1:0]     stick_x,
    input  wire logic [STICK_W-1:0]     stick_y,
    input  wire logic [NOW_W-1:0]       now_ms,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [BTN_W-1:0]            buttons_out,
    output logic [DIRS_W-1:0]           stick_dirs,
    output logic [STICK_W-1:0]          stick_x_out,
    output logic [STICK_W-1:0]          stick_y_out
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic               ar_en_reg;
    logic [DELAY_W-1:0] first_delay_reg;
    logic [DELAY_W-1:0] repeat_interval_reg;
    logic [STICK_W-1:0] stick_low_reg;
    logic [STICK_W-1:0] stick_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_en_reg           <= 1'b0;
            first_delay_reg     <= FIRST_DELAY_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
            stick_low_reg       <= STICK_LOW_RST;
            stick_high_reg      <= STICK_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            // mask each write to the register width; unknown indexes drop
            case (cfg_index)
                REG_AUTOREPEAT_ENABLE: ar_en_reg           <= cfg_data[0];
                REG_FIRST_DELAY:       first_delay_reg     <= cfg_data[DELAY_W-1:0];
                REG_REPEAT_INTERVAL:   repeat_interval_reg <= cfg_data[DELAY_W-1:0];
                REG_STICK_LOW:         stick_low_reg       <= cfg_data[STICK_W-1:0];
                REG_STICK_HIGH:        stick_high_reg      <= cfg_data[STICK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                  s1_valid_reg;
    logic [BTN_W-1:0]      s1_buttons_reg;
    logic [STICK_W-1:0]    s1_x_reg;
    logic [STICK_W-1:0]    s1_y_reg;
    logic [TIME_WIDTH-1:0] s1_now_reg;
    logic [TIME_WIDTH-1:0] now_fit;
    logic                  in_take;
    logic                  s1_adv;

    // Take now_ms modulo 2^TIME_WIDTH, zero-extended when the time is wider
    generate
        if (TIME_WIDTH > NOW_W)
        begin : g_now_wide
            assign now_fit = {{(TIME_WIDTH-NOW_W){1'b0}}, now_ms};
        end
        else if (TIME_WIDTH == NOW_W)
        begin : g_now_same
            assign now_fit = now_ms;
        end
        else
        begin : g_now_narrow
            assign now_fit = now_ms[TIME_WIDTH-1:0];
        end
    endgenerate

    // Advance the input register whenever the result register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_buttons_reg <= buttons_held;
            s1_x_reg       <= stick_x;
            s1_y_reg       <= stick_y;
            s1_now_reg     <= now_fit;
        end
    end

    // ---------------------------------------------------------------
    // Per-button autorepeat lanes; state commits as the item advances
    // ---------------------------------------------------------------
    bar_lane_ctl_t          lane_ctl;
    logic [NUM_BUTTONS-1:0] lane_report;
    logic [BTN_W-1:0]       btn_report;

    assign lane_ctl.advance         = s1_adv;
    assign lane_ctl.autorepeat      = ar_en_reg;
    assign lane_ctl.first_delay     = first_delay_reg;
    assign lane_ctl.repeat_interval = repeat_interval_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_BUTTONS; gi++)
        begin : g_lane
            logic lane_held;
            if (gi < BTN_W)
            begin : g_held
                assign lane_held = s1_buttons_reg[gi];
            end
            else
            begin : g_none
                // no input bit for this button: it is never held
                assign lane_held = 1'b0;
            end

            bar_button_lane #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (lane_ctl),
                .held   (lane_held),
                .now    (s1_now_reg),
                .report (lane_report[gi])
            );
        end

        for (gi = 0; gi < BTN_W; gi++)
        begin : g_out
            if (gi < NUM_BUTTONS)
            begin : g_lane_bit
                assign btn_report[gi] = lane_report[gi];
            end
            else
            begin : g_zero_bit
                assign btn_report[gi] = 1'b0;
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Stick direction thresholds: below-low wins over at-or-above-high
    // ---------------------------------------------------------------
    logic [DIRS_W-1:0] dirs;
    logic              y_low;
    logic              x_low;

    assign y_low = s1_y_reg < stick_low_reg;
    assign x_low = s1_x_reg < stick_low_reg;

    always_comb
    begin
        dirs            = '0;
        dirs[DIR_UP]    = y_low;
        dirs[DIR_DOWN]  = !y_low && (s1_y_reg >= stick_high_reg);
        dirs[DIR_LEFT]  = x_low;
        dirs[DIR_RIGHT] = !x_low && (s1_x_reg >= stick_high_reg);
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic               out_valid_reg;
    logic [BTN_W-1:0]   buttons_out_reg;
    logic [DIRS_W-1:0]  dirs_reg;
    logic [STICK_W-1:0] x_out_reg;
    logic [STICK_W-1:0] y_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            buttons_out_reg <= btn_report;
            dirs_reg        <= dirs;
            x_out_reg       <= s1_x_reg;
            y_out_reg       <= s1_y_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign buttons_out = buttons_out_reg;
    assign stick_dirs  = dirs_reg;
    assign stick_x_out = x_out_reg;
    assign stick_y_out = y_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `BAR_ASSERT_IMP(a_stall_needs_full_stage, in_stall, s1_valid_reg && out_valid_reg)
    `BAR_ASSERT_NXT(a_advance_fills_result, s1_adv, out_valid_reg)
    `BAR_ASSERT_NXT(a_report_within_held, s1_adv, (buttons_out & ~$past(s1_buttons_reg)) == '0)
    `BAR_ASSERT_NXT(a_passthrough_when_off, s1_adv && !ar_en_reg,
                    buttons_out == $past(btn_report) && stick_x_out == $past(s1_x_reg))

endmodule
`default_nettype wire
